### rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue cell chain.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_LIST      = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_t;

  // What every cell does this cycle
  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_SHR    = 3'd1,  // take left neighbor (insert at front)
    CM_SHL    = 3'd2,  // take right neighbor (remove from front)
    CM_APPEND = 3'd3,  // tail cell loads the word
    CM_ROTATE = 3'd4   // shift left, last occupied cell takes the head
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic signed [VAL_W-1:0]  data;
  } cell_ctl_t;

endpackage

### rtl/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One queue slot: holds a word and trades it with its neighbors.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                               clk,
  input  deq_pkg::cell_ctl_t                 ctl,
  input  logic signed [deq_pkg::VAL_W-1:0]   left_val,
  input  logic signed [deq_pkg::VAL_W-1:0]   right_val,
  input  logic signed [deq_pkg::VAL_W-1:0]   head_val,
  input  logic                               at_tail,
  input  logic                               at_last,
  output logic signed [deq_pkg::VAL_W-1:0]   val
);
  import deq_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.mode)
      CM_HOLD:   val_nxt = val_r;
      CM_SHR:    val_nxt = left_val;
      CM_SHL:    val_nxt = right_val;
      CM_APPEND: val_nxt = at_tail ? ctl.data : val_r;
      CM_ROTATE: val_nxt = at_last ? head_val : right_val;
      default:   val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

### rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Count, listing sequencer and result register for the queue cell chain.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [deq_pkg::OP_W-1:0]            in_operation,
  input  logic signed [deq_pkg::VAL_W-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [deq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [deq_pkg::VAL_W-1:0]    out_element,
  output logic                                out_last_of_run,
  input  logic signed [deq_pkg::VAL_W-1:0]    head_val,
  output deq_pkg::cell_ctl_t                  cell_ctl,
  output logic [deq_pkg::CNT_W-1:0]           count
);
  import deq_pkg::*;

  fsm_t                    state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  logic signed [VAL_W-1:0] elem_r, elem_nxt;
  logic                    last_r, last_nxt;
  logic                    out_free;
  logic                    full, empty;

  assign out_free = !out_valid_r || out_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_ready = (state_r == FSM_IDLE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    cell_ctl.mode = CM_HOLD;
    cell_ctl.data = in_value;

    case (state_r)
      FSM_IDLE: begin
        if (in_valid && in_ready) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          elem_nxt      = '0;
          last_nxt      = 1'b1;
          case (op_t'(in_operation))
            OP_INS_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cell_ctl.mode = CM_SHR;
                count_nxt     = count_r + 1'b1;
              end
            end
            OP_INS_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cell_ctl.mode = CM_APPEND;
                count_nxt     = count_r + 1'b1;
              end
            end
            OP_REM_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                cell_ctl.mode = CM_SHL;
                count_nxt     = count_r - 1'b1;
              end
            end
            OP_REM_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_LIST: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                // first word goes out now; ring turns once per word
                cell_ctl.mode = CM_ROTATE;
                elem_nxt      = head_val;
                last_nxt      = (count_r == CNT_W'(1));
                rem_nxt       = count_r - 1'b1;
                if (count_r != CNT_W'(1)) begin
                  state_nxt = FSM_LIST;
                end
              end
            end
            default: ;
          endcase
        end
      end
      FSM_LIST: begin
        if (out_free) begin
          cell_ctl.mode = CM_ROTATE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          elem_nxt      = head_val;
          last_nxt      = (rem_r == CNT_W'(1));
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    elem_r   <= elem_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_element     = elem_r;
  assign out_last_of_run = last_r;
  assign count           = count_r;

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// A result word is registered in the cycle after its input word is taken.
// Inserts and removals are taken back to back while results are drained; a
//   listing holds off the input until its last element has been given out.
// Reset clears the count, sequencer and result valid; cell contents are left
//   as they are and are never read before being written.
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [deq_pkg::OP_W-1:0]            in_operation,
  input  logic signed [deq_pkg::VAL_W-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [deq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [deq_pkg::VAL_W-1:0]    out_element,
  output logic                                out_last_of_run
);
  import deq_pkg::*;

  cell_ctl_t               cell_ctl;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] cell_val [DEPTH];

  deq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_element     (out_element),
    .out_last_of_run (out_last_of_run),
    .head_val        (cell_val[0]),
    .cell_ctl        (cell_ctl),
    .count           (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_ctl.data;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    deq_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .at_tail   (count == CNT_W'(i)),
      .at_last   (count == CNT_W'(i + 1)),
      .val       (cell_val[i])
    );
  end

endmodule
